// ===== hw/rtl/wrcv_pkg.sv =====
// Shared constants, types and state codes of the weightless RAM class voter.
package wrcv_pkg;

  localparam int TUPLE_BITS_DEF  = 8;
  localparam int RAM_COUNT_DEF   = 16;
  localparam int CLASS_COUNT_DEF = 10;

  localparam int RAM_NUM_W    = 4;
  localparam int TUPLE_ADDR_W = 8;
  localparam int CLASS_W      = 4;
  localparam int VOTE_W       = 16;
  localparam logic [VOTE_W-1:0] VOTE_MAX = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_TRAIN   = 1'b0,
    CMD_PREDICT = 1'b1
  } wrcv_cmd_t;

  typedef struct packed {
    logic train;
    logic vote;
    logic eos;
  } wrcv_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_EMIT
  } wrcv_state_t;

  typedef struct packed {
    logic pop_ok;
    logic clear_wr;
    logic emitting;
  } wrcv_ctrl_t;

endpackage

// ===== hw/rtl/wrcv_front.sv =====
// Front end: accepts commands, classifies them and forms store index and class mask.
module wrcv_front #(
  parameter int TUPLE_BITS  = wrcv_pkg::TUPLE_BITS_DEF,
  parameter int RAM_COUNT   = wrcv_pkg::RAM_COUNT_DEF,
  parameter int CLASS_COUNT = wrcv_pkg::CLASS_COUNT_DEF,
  localparam int IDX_W      = $clog2(RAM_COUNT << TUPLE_BITS)
) (
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [wrcv_pkg::RAM_NUM_W-1:0]    in_ram_number,
  input  logic [wrcv_pkg::TUPLE_ADDR_W-1:0] in_tuple_address,
  input  logic [wrcv_pkg::CLASS_W-1:0]      in_class_label,
  input  logic                              in_end_of_sample,
  input  logic                              clearing,
  input  logic                              q_full,
  output logic                              push,
  output wrcv_pkg::wrcv_op_t                push_op,
  output logic [IDX_W-1:0]                  push_idx,
  output logic [CLASS_COUNT-1:0]            push_mask
);

  logic hit;
  logic label_ok;

  assign busy     = clearing || q_full;
  assign hit      = {5'd0, in_ram_number} < 9'(RAM_COUNT);
  assign label_ok = in_class_label < wrcv_pkg::CLASS_W'(CLASS_COUNT);

  always_comb begin
    push_op.train = (in_command == wrcv_pkg::CMD_TRAIN) && hit && label_ok;
    push_op.vote  = (in_command == wrcv_pkg::CMD_PREDICT) && hit;
    push_op.eos   = (in_command == wrcv_pkg::CMD_PREDICT) && in_end_of_sample;
  end

  assign push_idx  = hit ? IDX_W'({in_ram_number, TUPLE_BITS'(in_tuple_address)}) : '0;
  assign push_mask = label_ok ? (CLASS_COUNT'(1) << in_class_label) : '0;

  // drop items that change nothing
  assign push = start && !busy && (push_op.train || push_op.vote || push_op.eos);

endmodule

// ===== hw/rtl/wrcv_queue.sv =====
// Short command queue between front end and back end.
module wrcv_queue #(
  parameter int IDX_W  = 12,
  parameter int MASK_W = wrcv_pkg::CLASS_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wrcv_pkg::wrcv_op_t push_op,
  input  logic [IDX_W-1:0]   push_idx,
  input  logic [MASK_W-1:0]  push_mask,
  output logic               full,
  output logic               q_valid,
  input  logic               pop,
  output wrcv_pkg::wrcv_op_t q_op,
  output logic [IDX_W-1:0]   q_idx,
  output logic [MASK_W-1:0]  q_mask
);

  localparam int PTR_W = $clog2(wrcv_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  wrcv_pkg::wrcv_op_t  op_q   [wrcv_pkg::QUEUE_DEPTH];
  logic [IDX_W-1:0]    idx_q  [wrcv_pkg::QUEUE_DEPTH];
  logic [MASK_W-1:0]   mask_q [wrcv_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == CNT_W'(wrcv_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_op    = op_q[rd_ptr_r];
  assign q_idx   = idx_q[rd_ptr_r];
  assign q_mask  = mask_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r]   <= push_op;
      idx_q[wr_ptr_r]  <= push_idx;
      mask_q[wr_ptr_r] <= push_mask;
    end
  end

endmodule

// ===== hw/rtl/wrcv_back.sv =====
// Back end: mark store with read-modify-write, vote counters, result emission, reset sweep.
module wrcv_back #(
  parameter int TUPLE_BITS  = wrcv_pkg::TUPLE_BITS_DEF,
  parameter int RAM_COUNT   = wrcv_pkg::RAM_COUNT_DEF,
  parameter int CLASS_COUNT = wrcv_pkg::CLASS_COUNT_DEF,
  localparam int IDX_W      = $clog2(RAM_COUNT << TUPLE_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  wrcv_pkg::wrcv_op_t           q_op,
  input  logic [IDX_W-1:0]             q_idx,
  input  logic [CLASS_COUNT-1:0]       q_mask,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  output logic [wrcv_pkg::CLASS_W-1:0] out_class_index,
  output logic [wrcv_pkg::VOTE_W-1:0]  out_vote_count,
  output logic                         out_last
);

  localparam int DEPTH  = RAM_COUNT << TUPLE_BITS;
  localparam int EMIT_W = $clog2(CLASS_COUNT);

  logic [CLASS_COUNT-1:0] mem [DEPTH];

  wrcv_pkg::wrcv_state_t state_r, state_nxt;
  wrcv_pkg::wrcv_ctrl_t  ctrl;

  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              clr_done;
  logic [EMIT_W-1:0] emit_idx_r, emit_idx_nxt;
  logic              emit_done;

  logic                   b_valid_r;
  wrcv_pkg::wrcv_op_t     b_op_r;
  logic [IDX_W-1:0]       b_idx_r;
  logic [CLASS_COUNT-1:0] b_mask_r;
  logic [CLASS_COUNT-1:0] rd_data_r;

  logic                   fwd_valid_r;
  logic [IDX_W-1:0]       fwd_idx_r;
  logic [CLASS_COUNT-1:0] fwd_data_r;

  logic [CLASS_COUNT-1:0] marks;
  logic                   mark_wr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [CLASS_COUNT-1:0] wr_data;

  logic [wrcv_pkg::VOTE_W-1:0] cnt_r   [CLASS_COUNT];
  logic [wrcv_pkg::VOTE_W-1:0] cnt_nxt [CLASS_COUNT];

  logic                         out_valid_r;
  logic [wrcv_pkg::CLASS_W-1:0] out_class_r;
  logic [wrcv_pkg::VOTE_W-1:0]  out_vote_r;
  logic                         out_last_r;

  assign clr_done  = clr_cnt_r == IDX_W'(DEPTH - 1);
  assign emit_done = emit_idx_r == EMIT_W'(CLASS_COUNT - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wrcv_pkg::ST_CLEAR: if (clr_done) state_nxt = wrcv_pkg::ST_RUN;
      wrcv_pkg::ST_RUN:   if (b_valid_r && b_op_r.eos) state_nxt = wrcv_pkg::ST_EMIT;
      wrcv_pkg::ST_EMIT:  if (emit_done) state_nxt = wrcv_pkg::ST_RUN;
      default:            state_nxt = wrcv_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      wrcv_pkg::ST_CLEAR: ctrl.clear_wr = 1'b1;
      wrcv_pkg::ST_RUN:   ctrl.pop_ok   = 1'b1;
      wrcv_pkg::ST_EMIT:  ctrl.emitting = 1'b1;
      default:            ctrl = '0;
    endcase
  end

  assign clearing = ctrl.clear_wr;
  // hold the queue while an end-of-sample item finishes its votes
  assign pop      = ctrl.pop_ok && q_valid && !(b_valid_r && b_op_r.eos);

  assign clr_cnt_nxt  = ctrl.clear_wr ? clr_cnt_r + IDX_W'(1) : '0;
  assign emit_idx_nxt = ctrl.emitting ? emit_idx_r + EMIT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrcv_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      emit_idx_r  <= '0;
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      b_valid_r   <= pop;
      fwd_valid_r <= mark_wr;
      out_valid_r <= ctrl.emitting;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op_r    <= q_op;
      b_idx_r   <= q_idx;
      b_mask_r  <= q_mask;
      rd_data_r <= mem[q_idx];
    end
  end

  // forward the write of the previous cycle, which the read just missed
  assign marks   = (fwd_valid_r && fwd_idx_r == b_idx_r) ? fwd_data_r : rd_data_r;
  assign mark_wr = b_valid_r && b_op_r.train;
  assign wr_en   = ctrl.clear_wr || mark_wr;
  assign wr_idx  = ctrl.clear_wr ? clr_cnt_r : b_idx_r;
  assign wr_data = ctrl.clear_wr ? '0 : (marks | b_mask_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx_r  <= b_idx_r;
    fwd_data_r <= wr_data;
  end

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      cnt_nxt[c] = cnt_r[c];
      if (b_valid_r && b_op_r.vote && marks[c] && cnt_r[c] != wrcv_pkg::VOTE_MAX) begin
        cnt_nxt[c] = cnt_r[c] + wrcv_pkg::VOTE_W'(1);
      end
    end
    if (ctrl.emitting) begin
      cnt_nxt[emit_idx_r] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        cnt_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emitting) begin
      out_class_r <= wrcv_pkg::CLASS_W'(emit_idx_r);
      out_vote_r  <= cnt_r[emit_idx_r];
      out_last_r  <= emit_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_index = out_class_r;
  assign out_vote_count  = out_vote_r;
  assign out_last        = out_last_r && out_valid_r;

endmodule

// ===== hw/rtl/weightless_ram_class_voter.sv =====
// Top level of the weightless RAM class voter.
//
// Command channel: an item (command, ram_number, tuple_address, class_label,
// end_of_sample) transfers at a rising edge with start high and busy low.
// Train sets the class mark of the addressed entry; predict adds one vote to
// every class marked in the addressed entry, saturating at 65535.
// Result channel: on a predict item with end_of_sample, CLASS_COUNT results
// follow on consecutive cycles, each valid for one cycle with out_valid, in
// class order, out_last on the final one; the counters then start from zero.
// The receiver cannot stall; results are never held back.
// Throughput: one item per cycle while busy is low. Outside the reset
// sweep, busy rises only while the four-entry command queue is full, which
// happens while results are emitted.
// Result path: the end-of-sample item passes through the command queue
// and the back-end item register, which moves control to the emit state;
// emission there is set by the single counter read per cycle.
// Reset: synchronous, active low. Afterwards the mark store is swept to zero,
// one entry per cycle over its RAM_COUNT * 2^TUPLE_BITS entries, busy high.
module weightless_ram_class_voter #(
  parameter int TUPLE_BITS  = wrcv_pkg::TUPLE_BITS_DEF,
  parameter int RAM_COUNT   = wrcv_pkg::RAM_COUNT_DEF,
  parameter int CLASS_COUNT = wrcv_pkg::CLASS_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [wrcv_pkg::RAM_NUM_W-1:0]    in_ram_number,
  input  logic [wrcv_pkg::TUPLE_ADDR_W-1:0] in_tuple_address,
  input  logic [wrcv_pkg::CLASS_W-1:0]      in_class_label,
  input  logic                              in_end_of_sample,
  output logic                              out_valid,
  output logic [wrcv_pkg::CLASS_W-1:0]      out_class_index,
  output logic [wrcv_pkg::VOTE_W-1:0]       out_vote_count,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(RAM_COUNT << TUPLE_BITS);

  logic                   clearing;
  logic                   q_full;
  logic                   push;
  wrcv_pkg::wrcv_op_t     push_op;
  logic [IDX_W-1:0]       push_idx;
  logic [CLASS_COUNT-1:0] push_mask;
  logic                   q_valid;
  logic                   pop;
  wrcv_pkg::wrcv_op_t     q_op;
  logic [IDX_W-1:0]       q_idx;
  logic [CLASS_COUNT-1:0] q_mask;

  wrcv_front #(
    .TUPLE_BITS  (TUPLE_BITS),
    .RAM_COUNT   (RAM_COUNT),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_front (
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_ram_number    (in_ram_number),
    .in_tuple_address (in_tuple_address),
    .in_class_label   (in_class_label),
    .in_end_of_sample (in_end_of_sample),
    .clearing         (clearing),
    .q_full           (q_full),
    .push             (push),
    .push_op          (push_op),
    .push_idx         (push_idx),
    .push_mask        (push_mask)
  );

  wrcv_queue #(
    .IDX_W  (IDX_W),
    .MASK_W (CLASS_COUNT)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .push_idx  (push_idx),
    .push_mask (push_mask),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_op      (q_op),
    .q_idx     (q_idx),
    .q_mask    (q_mask)
  );

  wrcv_back #(
    .TUPLE_BITS  (TUPLE_BITS),
    .RAM_COUNT   (RAM_COUNT),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .q_idx           (q_idx),
    .q_mask          (q_mask),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_class_index (out_class_index),
    .out_vote_count  (out_vote_count),
    .out_last        (out_last)
  );

endmodule

// ===== hw/rtl/wrcv_checker.sv =====
// Port-level checks of the weightless RAM class voter, bound to the top level.
module wrcv_checker #(
  parameter int CLASS_COUNT = wrcv_pkg::CLASS_COUNT_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         busy,
  input logic                         out_valid,
  input logic [wrcv_pkg::CLASS_W-1:0] out_class_index,
  input logic                         out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> busy && !out_valid)
    else $error("busy low or result after reset");

  a_first_class: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_class_index == '0)
    else $error("result burst does not start at class zero");

  a_class_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid &&
      out_class_index == $past(out_class_index) + wrcv_pkg::CLASS_W'(1))
    else $error("result burst broken or out of class order");

  a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_class_index == wrcv_pkg::CLASS_W'(CLASS_COUNT - 1))
    else $error("last flag on wrong class");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after last of a sample");

endmodule

bind weightless_ram_class_voter wrcv_checker #(.CLASS_COUNT(CLASS_COUNT)) u_checker (.*);

// ===== sim/tb_weightless_ram_class_voter.sv =====
// Self-checking testbench for the weightless RAM class voter: train/predict stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_weightless_ram_class_voter;

  localparam int CLASS_COUNT = wrcv_pkg::CLASS_COUNT_DEF;
  localparam int TUPLE_BITS  = wrcv_pkg::TUPLE_BITS_DEF;
  localparam int RAM_COUNT   = wrcv_pkg::RAM_COUNT_DEF;
  localparam int STORE_DEPTH = RAM_COUNT << TUPLE_BITS;
  localparam int RANDOM_ITEMS = 230;
  localparam int CALM_ITEMS   = 190;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [wrcv_pkg::CLASS_W-1:0] class_index;
    logic [wrcv_pkg::VOTE_W-1:0]  vote_count;
    logic                         last;
  } class_tally_t;

  class vote_scoreboard;
    logic [CLASS_COUNT-1:0]      entry_marks [STORE_DEPTH];
    logic [wrcv_pkg::VOTE_W-1:0] vote_tally [CLASS_COUNT];
    class_tally_t                expected_tally [$];
    int                          errors;

    function new();
      foreach (entry_marks[i]) entry_marks[i] = '0;
      foreach (vote_tally[i]) vote_tally[i] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_tally.size();
    endfunction

    function void note_item(wrcv_pkg::wrcv_cmd_t cmd, logic [wrcv_pkg::RAM_NUM_W-1:0] ram,
                            logic [wrcv_pkg::TUPLE_ADDR_W-1:0] addr,
                            logic [wrcv_pkg::CLASS_W-1:0] label, logic eos);
      int idx;
      bit hit;
      class_tally_t t;
      hit = (int'(ram) < RAM_COUNT);
      idx = int'(ram) * (1 << TUPLE_BITS) + (int'(addr) & ((1 << TUPLE_BITS) - 1));
      if (cmd == wrcv_pkg::CMD_TRAIN) begin
        if (hit && int'(label) < CLASS_COUNT) entry_marks[idx][label] = 1'b1;
        return;
      end
      if (hit) begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
          if (entry_marks[idx][c] && vote_tally[c] != wrcv_pkg::VOTE_MAX)
            vote_tally[c] = vote_tally[c] + 1'b1;
        end
      end
      if (!eos) return;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        t.class_index = c[wrcv_pkg::CLASS_W-1:0];
        t.vote_count  = vote_tally[c];
        t.last        = (c == CLASS_COUNT - 1);
        expected_tally = {expected_tally, t};
        vote_tally[c] = '0;
      end
    endfunction

    task check_result(logic [wrcv_pkg::CLASS_W-1:0] class_index,
                      logic [wrcv_pkg::VOTE_W-1:0] vote_count, logic last);
      class_tally_t t;
      if (expected_tally.size() == 0) begin
        report($sformatf("unexpected result class %0d count %0d", class_index, vote_count));
        return;
      end
      t = expected_tally.pop_front();
      if (class_index !== t.class_index)
        report($sformatf("class_index got %0d want %0d", class_index, t.class_index));
      if (vote_count !== t.vote_count)
        report($sformatf("vote_count class %0d got %0d want %0d",
                         t.class_index, vote_count, t.vote_count));
      if (last !== t.last)
        report($sformatf("last class %0d got %0b want %0b", t.class_index, last, t.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [wrcv_pkg::RAM_NUM_W-1:0]    in_ram_number;
  logic [wrcv_pkg::TUPLE_ADDR_W-1:0] in_tuple_address;
  logic [wrcv_pkg::CLASS_W-1:0]      in_class_label;
  logic in_end_of_sample;
  logic out_valid;
  logic [wrcv_pkg::CLASS_W-1:0] out_class_index;
  logic [wrcv_pkg::VOTE_W-1:0]  out_vote_count;
  logic out_last;

  vote_scoreboard sb = new();
  int cycle_count = 0;
  int sent;
  int burst;
  int pick;
  bit allow_idle;

  weightless_ram_class_voter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_ram_number    (in_ram_number),
    .in_tuple_address (in_tuple_address),
    .in_class_label   (in_class_label),
    .in_end_of_sample (in_end_of_sample),
    .out_valid        (out_valid),
    .out_class_index  (out_class_index),
    .out_vote_count   (out_vote_count),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_item(wrcv_pkg::wrcv_cmd_t'(in_command), in_ram_number, in_tuple_address,
                   in_class_label, in_end_of_sample);
    if (rst_n && out_valid)
      sb.check_result(out_class_index, out_vote_count, out_last);
  end

  task send_item(wrcv_pkg::wrcv_cmd_t cmd, int ram, int addr, int label, bit eos);
    start            <= 1'b1;
    in_command       <= cmd;
    in_ram_number    <= ram[wrcv_pkg::RAM_NUM_W-1:0];
    in_tuple_address <= addr[wrcv_pkg::TUPLE_ADDR_W-1:0];
    in_class_label   <= label[wrcv_pkg::CLASS_W-1:0];
    in_end_of_sample <= eos;
    do @(posedge clk); while (busy);
  endtask

  task idle_burst();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task send_random(wrcv_pkg::wrcv_cmd_t cmd, bit eos);
    int addr;
    addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
    send_item(cmd, $urandom_range(0, 15), addr, $urandom_range(0, 15), eos);
    idle_burst();
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_command       <= wrcv_pkg::CMD_TRAIN;
    in_ram_number    <= '0;
    in_tuple_address <= '0;
    in_class_label   <= '0;
    in_end_of_sample <= 1'b0;
    allow_idle = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(wrcv_pkg::CMD_TRAIN, 0, 0, 0, 1'b0);       idle_burst();
    send_item(wrcv_pkg::CMD_TRAIN, 15, 255, 9, 1'b0);    idle_burst();
    send_item(wrcv_pkg::CMD_TRAIN, 15, 255, 15, 1'b0);   idle_burst();
    send_item(wrcv_pkg::CMD_TRAIN, 15, 255, 10, 1'b0);   idle_burst();
    send_item(wrcv_pkg::CMD_TRAIN, 7, 128, 5, 1'b1);     idle_burst();
    send_item(wrcv_pkg::CMD_TRAIN, 7, 128, 3, 1'b0);     idle_burst();
    send_item(wrcv_pkg::CMD_TRAIN, 0, 0, 9, 1'b0);       idle_burst();
    send_item(wrcv_pkg::CMD_PREDICT, 0, 0, 15, 1'b0);    idle_burst();
    send_item(wrcv_pkg::CMD_PREDICT, 15, 255, 0, 1'b0);  idle_burst();
    send_item(wrcv_pkg::CMD_PREDICT, 7, 128, 10, 1'b1);  idle_burst();
    send_item(wrcv_pkg::CMD_PREDICT, 9, 77, 0, 1'b1);    idle_burst();
    send_item(wrcv_pkg::CMD_PREDICT, 0, 0, 0, 1'b1);
    send_item(wrcv_pkg::CMD_PREDICT, 15, 255, 9, 1'b1);
    send_item(wrcv_pkg::CMD_PREDICT, 7, 128, 5, 1'b1);   idle_burst();
    send_item(wrcv_pkg::CMD_PREDICT, 0, 0, 0, 1'b0);
    send_item(wrcv_pkg::CMD_PREDICT, 0, 0, 0, 1'b0);
    send_item(wrcv_pkg::CMD_TRAIN, 0, 0, 4, 1'b1);
    send_item(wrcv_pkg::CMD_PREDICT, 0, 0, 0, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      allow_idle = (sent < CALM_ITEMS);
      if (sent > 120 && sent < 130) begin
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      pick  = $urandom_range(0, 9);
      burst = $urandom_range(2, 8);
      if (pick < 4) begin
        for (int i = 0; i < burst; i++)
          send_random(wrcv_pkg::CMD_TRAIN, 1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        for (int i = 0; i < burst; i++)
          send_random(wrcv_pkg::CMD_PREDICT, (i == burst - 1) || ($urandom_range(0, 15) == 0));
      end else begin
        for (int i = 0; i < burst; i++)
          send_random(wrcv_pkg::wrcv_cmd_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      sent += burst;
    end
    send_item(wrcv_pkg::CMD_PREDICT, $urandom_range(0, 15), $urandom_range(0, 7), 0, 1'b1);
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
